// File: design/pfp_pkg.sv
// ----------------------------------------------------------------------------
// pfp_pkg : shared types and constants of the palette format packer
// Register map, queue entry layout, op codes and the mask-normalising helpers.
// ----------------------------------------------------------------------------
package pfp_pkg;

   localparam int PFP_ENTRIES_DEFAULT = 256;
   localparam int PFP_QUEUE_DEPTH     = 2;
   localparam int PFP_ADDR_W          = 4;
   localparam int PFP_DATA_W          = 32;

   // register indexes (byte address = 4 * index)
   typedef logic [1:0] reg_idx_type;
   localparam reg_idx_type REG_PIXEL_MODE = 2'd0;
   localparam reg_idx_type REG_RED_MASK   = 2'd1;
   localparam reg_idx_type REG_GREEN_MASK = 2'd2;
   localparam reg_idx_type REG_BLUE_MASK  = 2'd3;

   // pixel modes
   typedef logic [1:0] mode_type;
   localparam mode_type MODE_INDEX = 2'd0;
   localparam mode_type MODE_16    = 2'd1;
   localparam mode_type MODE_24    = 2'd2;
   localparam mode_type MODE_32    = 2'd3;

   // item kinds
   localparam logic KIND_WRITE  = 1'b0;
   localparam logic KIND_LOOKUP = 1'b1;

   // channel masks: RGB reset values, fixed 16-bit layouts and the 16-bit keep mask
   localparam logic [31:0] RGB_RED   = 32'h00ff_0000;
   localparam logic [31:0] RGB_GREEN = 32'h0000_ff00;
   localparam logic [31:0] RGB_BLUE  = 32'h0000_00ff;
   localparam logic [31:0] M555_RED   = 32'h0000_7c00;
   localparam logic [31:0] M555_GREEN = 32'h0000_03e0;
   localparam logic [31:0] M565_RED   = 32'h0000_f800;
   localparam logic [31:0] M565_GREEN = 32'h0000_07e0;
   localparam logic [31:0] M5_BLUE    = 32'h0000_001f;
   localparam logic [31:0] KEEP_16    = 32'h0000_ffff;

   // cycles for the derived shift registers to catch up after a write
   localparam logic [1:0] SETTLE_CYCLES = 2'd2;

   // queue ops
   typedef logic [1:0] op_type;
   localparam op_type OP_WRITE  = 2'd0;   // store packed word
   localparam op_type OP_READ   = 2'd1;   // answer from palette
   localparam op_type OP_DIRECT = 2'd2;   // answer carried in the entry

   typedef struct packed {
      mode_type    pixel_mode;
      logic [31:0] red_mask;
      logic [31:0] green_mask;
      logic [31:0] blue_mask;
   } cfg_type;

   typedef struct packed {
      op_type      op;
      logic [7:0]  index;
      logic [31:0] data;
      logic        error;
   } entry_type;

   // per-byte summary of a mask
   typedef struct packed {
      logic [3:0]      nz;
      logic [3:0][2:0] pos;
      logic            low_full;
   } mask_info_type;

   typedef struct packed {
      logic       left;
      logic [4:0] amt;
   } shift_type;

   typedef struct packed {
      logic rgb;
      logic bgr;
      logic r555;
      logic r565;
   } fmt_flags_type;

   function automatic logic [2:0] byte_msb(input logic [7:0] b);
      logic [2:0] p;
      p = 3'd0;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) begin
            p = 3'(i);
         end
      end
      return p;
   endfunction

   function automatic mask_info_type mask_info(input logic [31:0] mask);
      mask_info_type mi;
      for (int b = 0; b < 4; b++) begin
         mi.nz[b]  = |mask[8*b +: 8];
         mi.pos[b] = byte_msb(mask[8*b +: 8]);
      end
      // low byte is exactly 0xff: already normalised, no shift
      mi.low_full = mask[7:0] == 8'hff;
      return mi;
   endfunction

   function automatic shift_type shift_of(input mask_info_type mi);
      shift_type  sh;
      logic [1:0] top;
      logic [4:0] p;
      if (mi.nz[3]) begin
         top = 2'd3;
      end else if (mi.nz[2]) begin
         top = 2'd2;
      end else if (mi.nz[1]) begin
         top = 2'd1;
      end else begin
         top = 2'd0;
      end
      p = {top, mi.pos[top]};
      if (top != 2'd0) begin
         sh.left = 1'b1;
         sh.amt  = p - 5'd7;
      end else begin
         // below 0xff the mask doubles until its top bit passes bit 7
         sh.left = 1'b0;
         sh.amt  = mi.low_full ? 5'd0 : (5'd8 - p);
      end
      return sh;
   endfunction

   function automatic logic [31:0] place(input logic [7:0] chan, input logic [31:0] mask,
                                          input shift_type sh);
      logic [31:0] w;
      logic [31:0] v;
      w = {24'h0, chan};
      v = sh.left ? (w << sh.amt) : (w >> sh.amt);
      return v & mask;
   endfunction

endpackage

// File: design/pfp_ram.sv
// ----------------------------------------------------------------------------
// pfp_ram : generic single-port RAM
// One access per cycle, write or read, read data registered.
// ----------------------------------------------------------------------------
module pfp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: design/pfp_csr.sv
// ----------------------------------------------------------------------------
// pfp_csr : configuration registers
// APB-style write and read-back of mode and the three channel masks.
// ----------------------------------------------------------------------------
module pfp_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [pfp_pkg::PFP_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready,
   output pfp_pkg::cfg_type             cfg,
   output logic                         cfg_write
);

   pfp_pkg::cfg_type    cfg_ff, cfg_in;
   pfp_pkg::reg_idx_type idx;

   assign idx        = csr_paddr[3:2];
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_write) begin
         unique case (idx)
            pfp_pkg::REG_PIXEL_MODE: cfg_in.pixel_mode = csr_pwdata[1:0];
            pfp_pkg::REG_RED_MASK:   cfg_in.red_mask   = csr_pwdata;
            pfp_pkg::REG_GREEN_MASK: cfg_in.green_mask = csr_pwdata;
            pfp_pkg::REG_BLUE_MASK:  cfg_in.blue_mask  = csr_pwdata;
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pixel_mode <= pfp_pkg::MODE_32;
         cfg_ff.red_mask   <= pfp_pkg::RGB_RED;
         cfg_ff.green_mask <= pfp_pkg::RGB_GREEN;
         cfg_ff.blue_mask  <= pfp_pkg::RGB_BLUE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (idx)
         pfp_pkg::REG_PIXEL_MODE: csr_prdata = {30'h0, cfg_ff.pixel_mode};
         pfp_pkg::REG_RED_MASK:   csr_prdata = cfg_ff.red_mask;
         pfp_pkg::REG_GREEN_MASK: csr_prdata = cfg_ff.green_mask;
         pfp_pkg::REG_BLUE_MASK:  csr_prdata = cfg_ff.blue_mask;
         default:                 csr_prdata = 32'h0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// File: design/pfp_front.sv
// ----------------------------------------------------------------------------
// pfp_front : request intake and classification
// Derives channel shifts from the masks, packs colours, tags each item.
// ----------------------------------------------------------------------------
module pfp_front #(
   parameter int PALETTE_ENTRIES = pfp_pkg::PFP_ENTRIES_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  pfp_pkg::cfg_type    cfg,
   input  logic                cfg_write,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_kind,
   input  logic [7:0]          req_color_index,
   input  logic [7:0]          req_red_in,
   input  logic [7:0]          req_green_in,
   input  logic [7:0]          req_blue_in,
   input  logic [7:0]          req_alpha_in,
   input  logic                q_full,
   output logic                push,
   output pfp_pkg::entry_type  push_entry
);

   logic [1:0]                settle_ff, settle_in;
   pfp_pkg::mask_info_type    info_ff [3];
   pfp_pkg::fmt_flags_type    flags_ff, flags_in;
   pfp_pkg::shift_type        shift_ff [3];

   logic        accept;
   logic        in_range;
   logic        bad24;
   logic [31:0] generic;
   logic [31:0] packed_word;

   // hold off intake until the derived shifts reflect the latest masks
   assign settle_in = cfg_write ? pfp_pkg::SETTLE_CYCLES :
                      (settle_ff != 2'd0) ? settle_ff - 2'd1 : 2'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= pfp_pkg::SETTLE_CYCLES;
      end else begin
         settle_ff <= settle_in;
      end
   end

   always_comb begin
      flags_in.rgb  = cfg.red_mask == pfp_pkg::RGB_RED && cfg.green_mask == pfp_pkg::RGB_GREEN
                      && cfg.blue_mask == pfp_pkg::RGB_BLUE;
      flags_in.bgr  = cfg.red_mask == pfp_pkg::RGB_BLUE && cfg.green_mask == pfp_pkg::RGB_GREEN
                      && cfg.blue_mask == pfp_pkg::RGB_RED;
      flags_in.r555 = cfg.red_mask == pfp_pkg::M555_RED
                      && cfg.green_mask == pfp_pkg::M555_GREEN
                      && cfg.blue_mask == pfp_pkg::M5_BLUE;
      flags_in.r565 = cfg.red_mask == pfp_pkg::M565_RED
                      && cfg.green_mask == pfp_pkg::M565_GREEN
                      && cfg.blue_mask == pfp_pkg::M5_BLUE;
   end

   // two-step shift search: per-byte summary, then top byte and distance
   always_ff @(posedge clock) begin
      info_ff[0]  <= pfp_pkg::mask_info(cfg.red_mask);
      info_ff[1]  <= pfp_pkg::mask_info(cfg.green_mask);
      info_ff[2]  <= pfp_pkg::mask_info(cfg.blue_mask);
      flags_ff    <= flags_in;
      for (int c = 0; c < 3; c++) begin
         shift_ff[c] <= pfp_pkg::shift_of(info_ff[c]);
      end
   end

   assign req_ready = !q_full && settle_ff == 2'd0;
   assign accept    = req_valid && req_ready;
   assign in_range  = {1'b0, req_color_index} < 9'(PALETTE_ENTRIES);
   assign bad24     = cfg.pixel_mode == pfp_pkg::MODE_24 && !flags_ff.rgb && !flags_ff.bgr;

   assign generic = pfp_pkg::place(req_red_in,   cfg.red_mask,   shift_ff[0])
                  | pfp_pkg::place(req_green_in, cfg.green_mask, shift_ff[1])
                  | pfp_pkg::place(req_blue_in,  cfg.blue_mask,  shift_ff[2]);

   always_comb begin
      if (cfg.pixel_mode == pfp_pkg::MODE_16) begin
         if (flags_ff.r555) begin
            packed_word = ((32'(req_red_in) << 7) & pfp_pkg::M555_RED)
                        | ((32'(req_green_in) << 2) & pfp_pkg::M555_GREEN)
                        | ((32'(req_blue_in) >> 3) & pfp_pkg::M5_BLUE);
         end else if (flags_ff.r565) begin
            packed_word = ((32'(req_red_in) << 8) & pfp_pkg::M565_RED)
                        | ((32'(req_green_in) << 3) & pfp_pkg::M565_GREEN)
                        | ((32'(req_blue_in) >> 3) & pfp_pkg::M5_BLUE);
         end else begin
            packed_word = generic & pfp_pkg::KEEP_16;
         end
      end else if (flags_ff.rgb) begin
         packed_word = {(cfg.pixel_mode == pfp_pkg::MODE_32) ? req_alpha_in : 8'h00,
                        req_red_in, req_green_in, req_blue_in};
      end else if (flags_ff.bgr) begin
         packed_word = {8'h00, req_blue_in, req_green_in, req_red_in};
      end else begin
         packed_word = generic;
      end
   end

   always_comb begin
      push_entry.index = req_color_index;
      push_entry.data  = packed_word;
      push_entry.error = 1'b0;
      push_entry.op    = pfp_pkg::OP_WRITE;
      push             = 1'b0;
      if (req_kind == pfp_pkg::KIND_WRITE) begin
         push = accept && cfg.pixel_mode != pfp_pkg::MODE_INDEX && in_range;
      end else begin
         push = accept;
         if (cfg.pixel_mode == pfp_pkg::MODE_INDEX) begin
            push_entry.op   = pfp_pkg::OP_DIRECT;
            push_entry.data = {24'h0, req_color_index};
         end else if (bad24) begin
            push_entry.op    = pfp_pkg::OP_DIRECT;
            push_entry.data  = 32'h0;
            push_entry.error = 1'b1;
         end else if (!in_range) begin
            push_entry.op   = pfp_pkg::OP_DIRECT;
            push_entry.data = 32'h0;
         end else begin
            push_entry.op = pfp_pkg::OP_READ;
         end
      end
   end

endmodule

// File: design/pfp_queue.sv
// ----------------------------------------------------------------------------
// pfp_queue : short FIFO between front and back
// Holds classified items so either side may stall on its own.
// ----------------------------------------------------------------------------
module pfp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  pfp_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output logic               not_empty,
   output pfp_pkg::entry_type head
);

   localparam int DEPTH = pfp_pkg::PFP_QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   pfp_pkg::entry_type slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full      = count_ff == CNT_W'(DEPTH);
   assign not_empty = count_ff != '0;
   assign head      = slot_ff[rd_ptr_ff];

   assign wr_ptr_in = !push ? wr_ptr_ff :
                      (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_ptr_in = !pop ? rd_ptr_ff :
                      (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: design/pfp_back.sv
// ----------------------------------------------------------------------------
// pfp_back : palette store and response path
// Writes and reads the palette RAM, then a result register toward rsp_.
// ----------------------------------------------------------------------------
module pfp_back #(
   parameter int PALETTE_ENTRIES = pfp_pkg::PFP_ENTRIES_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  pfp_pkg::entry_type head,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [31:0]        rsp_pixel_out,
   output logic               rsp_format_error
);

   localparam int AW = $clog2(PALETTE_ENTRIES);

   logic        a_valid_ff, a_valid_in;
   logic        a_from_ram_ff;
   logic [31:0] a_data_ff;
   logic        a_error_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_pixel_ff;
   logic        rsp_error_ff;

   logic        head_write;
   logic        a_adv;
   logic [31:0] ram_rdata;

   assign head_write = head.op == pfp_pkg::OP_WRITE;
   assign a_adv      = a_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign pop        = q_valid && (head_write || !a_valid_ff || a_adv);

   pfp_ram #(
      .WIDTH (pfp_pkg::PFP_DATA_W),
      .DEPTH (PALETTE_ENTRIES)
   ) u_ram (
      .clock (clock),
      .en    (pop && (head_write || head.op == pfp_pkg::OP_READ)),
      .we    (head_write),
      .addr  (head.index[AW-1:0]),
      .wdata (head.data),
      .rdata (ram_rdata)
   );

   assign a_valid_in   = (pop && !head_write) ? 1'b1 : a_adv ? 1'b0 : a_valid_ff;
   assign rsp_valid_in = a_adv ? 1'b1 : rsp_ready ? 1'b0 : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && !head_write) begin
         a_from_ram_ff <= head.op == pfp_pkg::OP_READ;
         a_data_ff     <= head.data;
         a_error_ff    <= head.error && head.op != pfp_pkg::OP_READ;
      end
      if (a_adv) begin
         rsp_pixel_ff <= a_from_ram_ff ? ram_rdata : a_data_ff;
         rsp_error_ff <= a_error_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pixel_out    = rsp_pixel_ff;
   assign rsp_format_error = rsp_error_ff;

endmodule

// File: design/palette_format_packer.sv
// ----------------------------------------------------------------------------
// palette_format_packer : display palette storing colours in pixel format
// Writes are packed to the configured layout and stored; lookups give the
// stored word, the index (mode 0), 0 beyond the palette or a format error.
// ----------------------------------------------------------------------------
//
//   channel   prefix  direction  transfer carries
//   -------   ------  ---------  -------------------------------------------
//   request   req_    in         kind, index, red, green, blue, alpha
//   response  rsp_    out        packed pixel, format error flag
//   config    csr_    in/out     APB-style: mode, red/green/blue masks
//
// One transfer per cycle each way when nothing stalls; a lookup's response
// passes the queue, RAM read and result registers. The palette RAM port
// is shared by writes and reads: one item per cycle unless a lookup waits
// on the result stage. After reset and after any register write req_ready
// stays low while the mask shifts are recomputed; the RAM is not cleared.
// A two-entry queue decouples intake from the RAM side, so rsp_ready low
// only stalls req_ready once the queue and the result stages are full.
//
module palette_format_packer #(
   parameter int PALETTE_ENTRIES = pfp_pkg::PFP_ENTRIES_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_kind,
   input  logic [7:0]                     req_color_index,
   input  logic [7:0]                     req_red_in,
   input  logic [7:0]                     req_green_in,
   input  logic [7:0]                     req_blue_in,
   input  logic [7:0]                     req_alpha_in,
   // response channel
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [31:0]                    rsp_pixel_out,
   output logic                           rsp_format_error,
   // configuration port
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [pfp_pkg::PFP_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);

   pfp_pkg::cfg_type   cfg;
   logic               cfg_write;
   logic               q_full;
   logic               q_push;
   logic               q_pop;
   logic               q_valid;
   pfp_pkg::entry_type q_in;
   pfp_pkg::entry_type q_head;

   // registers; a write pulse restarts the front's settle count
   pfp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg),
      .cfg_write   (cfg_write)
   );

   // intake: packs writes, resolves passthrough / error / range lookups
   pfp_front #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .cfg_write       (cfg_write),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_color_index (req_color_index),
      .req_red_in      (req_red_in),
      .req_green_in    (req_green_in),
      .req_blue_in     (req_blue_in),
      .req_alpha_in    (req_alpha_in),
      .q_full          (q_full),
      .push            (q_push),
      .push_entry      (q_in)
   );

   pfp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_in),
      .full       (q_full),
      .pop        (q_pop),
      .not_empty  (q_valid),
      .head       (q_head)
   );

   // RAM side: store, fetch, hold the result until rsp_ready
   pfp_back #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .head             (q_head),
      .pop              (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pixel_out    (rsp_pixel_out),
      .rsp_format_error (rsp_format_error)
   );

endmodule

// File: design/pfp_checker.sv
// ----------------------------------------------------------------------------
// pfp_checker : port-level checks on the palette format packer
// Watches the top-level ports only; bound to every instance.
// ----------------------------------------------------------------------------
module pfp_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [31:0]                    rsp_pixel_out,
   input logic                           rsp_format_error,
   input logic                           csr_psel,
   input logic                           csr_penable,
   input logic                           csr_pwrite,
   input logic                           csr_pready
);

   // a held response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_out)
                                  && $stable(rsp_format_error))
      else $error("response changed while stalled");

   // nothing comes out straight after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // intake pauses while mask shifts are rederived
   a_settle: assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite |=> !req_ready)
      else $error("request taken right after register write");

   // an error result carries no pixel
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_format_error |-> rsp_pixel_out == 32'h0)
      else $error("format error with non-zero pixel");

   a_pready: assert property (@(posedge clock) disable iff (reset)
      csr_pready)
      else $error("pready low");

endmodule

bind palette_format_packer pfp_checker u_pfp_checker (.*);

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb : self-checking testbench for palette_format_packer
// Drives palette writes and pixel lookups over valid/ready and reprograms
// the pixel mode and channel masks over the APB-style port between bursts.
// A shadow palette, packed here in every format, predicts each lookup
// response, and the response monitor checks it field by field.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pfp_pkg::*;

   // cycles allowed after the last expected response before touching the
   // registers or ending: queue, RAM read and result stages plus the settle
   localparam int DRAIN_CYCLES = 8;

   typedef struct packed {
      logic [31:0] pixel;
      logic        error;
   } pixel_expect_t;

   // ---------------------------------------------------------------- DUT I/O
   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid       = 1'b0;
   logic        req_ready;
   logic        req_kind        = KIND_WRITE;
   logic [7:0]  req_color_index = 8'h00;
   logic [7:0]  req_red_in      = 8'h00;
   logic [7:0]  req_green_in    = 8'h00;
   logic [7:0]  req_blue_in     = 8'h00;
   logic [7:0]  req_alpha_in    = 8'h00;

   logic        rsp_valid;
   logic        rsp_ready       = 1'b0;
   logic [31:0] rsp_pixel_out;
   logic        rsp_format_error;

   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [PFP_ADDR_W-1:0] csr_paddr   = '0;
   logic [31:0]           csr_pwdata  = 32'h0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   palette_format_packer DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_color_index  (req_color_index),
      .req_red_in       (req_red_in),
      .req_green_in     (req_green_in),
      .req_blue_in      (req_blue_in),
      .req_alpha_in     (req_alpha_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pixel_out    (rsp_pixel_out),
      .rsp_format_error (rsp_format_error),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   // ------------------------------------------------------ shadow of the block
   // register copies, at their reset values
   mode_type    cfg_mode  = MODE_32;
   logic [31:0] cfg_red   = RGB_RED;
   logic [31:0] cfg_green = RGB_GREEN;
   logic [31:0] cfg_blue  = RGB_BLUE;

   // packed words as the block should hold them; only written entries are read
   logic [31:0] shadow_palette [256];
   bit          entry_written  [256];
   logic [7:0]  written_list   [$];

   // lookups accepted whose responses have not yet come back, oldest first
   pixel_expect_t pending_pixels [$];

   // run-time knobs: percentage of cycles spent idle / stalled
   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   logic        rsp_hold      = 1'b0;

   int unsigned fail_count = 0;
   int unsigned n_writes   = 0;
   int unsigned n_lookups  = 0;
   int unsigned n_results  = 0;
   int unsigned n_configs  = 0;

   // ------------------------------------------------------------------ clock
   initial begin
      forever #5 clock = ~clock;
   end

   // the run is far shorter than this even with every stall phase at its worst
   initial begin
      #2_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   // --------------------------------------------------------- packing rules
   function automatic bit masks_rgb();
      return cfg_red == RGB_RED && cfg_green == RGB_GREEN && cfg_blue == RGB_BLUE;
   endfunction

   function automatic bit masks_bgr();
      return cfg_red == RGB_BLUE && cfg_green == RGB_GREEN && cfg_blue == RGB_RED;
   endfunction

   function automatic bit bad_24bit();
      return cfg_mode == MODE_24 && !masks_rgb() && !masks_bgr();
   endfunction

   // shift a channel by the distance that brings its mask to 0xff, then mask
   function automatic logic [31:0] place_chan(input logic [7:0] chan,
                                              input logic [31:0] mask);
      logic [31:0] m;
      int unsigned sh;
      m  = mask;
      sh = 0;
      if (mask == 32'h0) begin
         return 32'h0;
      end
      if (mask >= 32'hff) begin
         while (m > 32'hff && sh < 31) begin
            m = m >> 1;
            sh++;
         end
         return ({24'h0, chan} << sh) & mask;
      end
      while (m < 32'hff && sh < 8) begin
         m = m << 1;
         sh++;
      end
      return ({24'h0, chan} >> sh) & mask;
   endfunction

   function automatic logic [31:0] pack_pixel(input logic [7:0] r, g, b, a);
      logic [31:0] rw, gw, bw, word;
      rw = {24'h0, r};
      gw = {24'h0, g};
      bw = {24'h0, b};
      if (cfg_mode == MODE_16) begin
         if (cfg_red == M555_RED && cfg_green == M555_GREEN && cfg_blue == M5_BLUE) begin
            return ((rw << 7) & M555_RED) | ((gw << 2) & M555_GREEN) | ((bw >> 3) & M5_BLUE);
         end
         if (cfg_red == M565_RED && cfg_green == M565_GREEN && cfg_blue == M5_BLUE) begin
            return ((rw << 8) & M565_RED) | ((gw << 3) & M565_GREEN) | ((bw >> 3) & M5_BLUE);
         end
         // generic 16-bit: shifts from the full masks, then cut to 16 bits
         return (place_chan(r, cfg_red) | place_chan(g, cfg_green) |
                 place_chan(b, cfg_blue)) & KEEP_16;
      end
      if (masks_rgb()) begin
         word = {8'h00, r, g, b};
         if (cfg_mode == MODE_32) begin
            word[31:24] = a;
         end
         return word;
      end
      if (masks_bgr()) begin
         return {8'h00, b, g, r};
      end
      // includes the bad 24-bit case, which still stores the 32-bit packing
      return place_chan(r, cfg_red) | place_chan(g, cfg_green) | place_chan(b, cfg_blue);
   endfunction

   // apply one accepted transfer to the shadow state; a lookup also queues its expected response
   function automatic void track_item(input logic kind, input logic [7:0] idx,
                                      input logic [7:0] r, g, b, a);
      pixel_expect_t e;
      if (kind == KIND_WRITE) begin
         n_writes++;
         // writes in index mode are dropped and leave the old word
         if (cfg_mode != MODE_INDEX) begin
            shadow_palette[idx] = pack_pixel(r, g, b, a);
            if (!entry_written[idx]) begin
               entry_written[idx] = 1'b1;
               written_list.push_back(idx);
            end
         end
      end else begin
         n_lookups++;
         if (cfg_mode == MODE_INDEX) begin
            e.pixel = {24'h0, idx};
            e.error = 1'b0;
         end else if (bad_24bit()) begin
            e.pixel = 32'h0;
            e.error = 1'b1;
         end else begin
            e.pixel = shadow_palette[idx];
            e.error = 1'b0;
         end
         pending_pixels.push_back(e);
      end
   endfunction

   // ------------------------------------------------------- request driver
   // Called at a rising edge; returns at the edge the transfer happens on.
   // req_valid stays high afterwards so a back-to-back item needs no dip.
   task automatic send_item(input logic kind, input logic [7:0] idx,
                            input logic [7:0] r, g, b, a);
      bit ready_seen;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_kind        <= kind;
      req_color_index <= idx;
      req_red_in      <= r;
      req_green_in    <= g;
      req_blue_in     <= b;
      req_alpha_in    <= a;
      // ready sampled mid-cycle: it holds until the coming edge
      do begin
         @(negedge clock);
         ready_seen = (req_ready === 1'b1);
         @(posedge clock);
      end while (!ready_seen);
      track_item(kind, idx, r, g, b, a);
   endtask

   // drop valid and let every expected response come home, plus the pipe
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------ register access
   task automatic csr_write(input reg_idx_type idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      // access phase: pready is tied high so the write lands on the next edge
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(input mode_type mode, input logic [31:0] rm, gm, bm);
      wait_for_results();
      csr_write(REG_PIXEL_MODE, {30'h0, mode});
      csr_write(REG_RED_MASK, rm);
      csr_write(REG_GREEN_MASK, gm);
      csr_write(REG_BLUE_MASK, bm);
      cfg_mode  = mode;
      cfg_red   = rm;
      cfg_green = gm;
      cfg_blue  = bm;
      n_configs++;
   endtask

   // ------------------------------------------------------ random helpers
   function automatic logic [7:0] random_byte();
      case ($urandom_range(0, 9))
         0:       return 8'h00;
         1:       return 8'hff;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [31:0] random_mask();
      logic [63:0] field;
      int unsigned w, p;
      w = $urandom_range(1, 12);
      p = $urandom_range(0, 31);
      field = ((64'd1 << w) - 64'd1) << p;
      case ($urandom_range(0, 7))
         0:       return 32'h0;
         1:       return 32'hffff_ffff;
         2:       return $urandom();
         3:       return 32'h1 << p;
         4:       return field[31:0];
         5:       return 32'hff << (8 * $urandom_range(0, 3));
         6:       return $urandom_range(1, 254);   // below 0xff: shifts right
         default: return $urandom_range(0, 65535);
      endcase
   endfunction

   task automatic random_config();
      mode_type    m;
      logic [31:0] rm, gm, bm;
      m = ($urandom_range(0, 9) == 0) ? MODE_INDEX : mode_type'($urandom_range(1, 3));
      case ($urandom_range(0, 5))
         0: begin
            rm = RGB_RED;  gm = RGB_GREEN; bm = RGB_BLUE;
         end
         1: begin
            rm = RGB_BLUE; gm = RGB_GREEN; bm = RGB_RED;
         end
         2: begin
            rm = M555_RED; gm = M555_GREEN; bm = M5_BLUE;
         end
         3: begin
            rm = M565_RED; gm = M565_GREEN; bm = M5_BLUE;
         end
         default: begin
            rm = random_mask(); gm = random_mask(); bm = random_mask();
         end
      endcase
      set_config(m, rm, gm, bm);
   endtask

   // mixed writes and lookups; lookups hit written entries unless the answer
   // never comes from the RAM (index mode, bad 24-bit masks)
   task automatic random_batch(input int count);
      logic [7:0] idx;
      bit         do_lookup;
      bit         no_read;
      repeat (count) begin
         no_read   = (cfg_mode == MODE_INDEX) || bad_24bit();
         do_lookup = $urandom_range(0, 1);
         if (do_lookup && !no_read && written_list.size() == 0) begin
            do_lookup = 1'b0;
         end
         if (do_lookup) begin
            if (no_read) begin
               idx = $urandom_range(0, 255);
            end else begin
               idx = written_list[$urandom_range(0, written_list.size() - 1)];
            end
            send_item(KIND_LOOKUP, idx, random_byte(), random_byte(), random_byte(),
                      random_byte());
         end else begin
            // a small hot set gets overwritten often
            idx = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 15))
                                              : 8'($urandom_range(0, 255));
            send_item(KIND_WRITE, idx, random_byte(), random_byte(), random_byte(),
                      random_byte());
         end
      end
   endtask

   // --------------------------------------------------- response side
   // rsp_ready: random stalls, or held low for a counted stretch
   always @(posedge clock) begin
      if (rsp_hold) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task automatic hold_responses(input int cycles);
      rsp_hold <= 1'b1;
      repeat (cycles) @(posedge clock);
      rsp_hold <= 1'b0;
   endtask

   // sample mid-cycle, act on the edge: a transfer is valid && ready there
   logic          rsp_fire = 1'b0;
   logic [31:0]   rsp_pixel_seen;
   logic          rsp_error_seen;
   pixel_expect_t want;

   always @(negedge clock) begin
      rsp_fire       <= (rsp_valid === 1'b1) && (rsp_ready === 1'b1);
      rsp_pixel_seen <= rsp_pixel_out;
      rsp_error_seen <= rsp_format_error;
   end

   always @(posedge clock) begin
      if (rsp_fire) begin
         n_results++;
         if (pending_pixels.size() == 0) begin
            $display("%0t ns: response with none expected, got pixel %08h error %b",
                     $time, rsp_pixel_seen, rsp_error_seen);
            fail_count++;
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_pixel_seen !== want.pixel) begin
               $display("%0t ns: pixel_out expected %08h, got %08h",
                        $time, want.pixel, rsp_pixel_seen);
               fail_count++;
            end
            if (rsp_error_seen !== want.error) begin
               $display("%0t ns: format_error expected %b, got %b",
                        $time, want.error, rsp_error_seen);
               fail_count++;
            end
         end
      end
   end

   // ----------------------------------------------------------- test tasks
   // reset layout is 32-bit RGB: alpha rides in the top byte
   task automatic test_reset_defaults();
      send_item(KIND_WRITE,  8'd0,   8'hff, 8'h00, 8'h80, 8'hff);
      send_item(KIND_WRITE,  8'd255, 8'h00, 8'hff, 8'h01, 8'h00);
      send_item(KIND_LOOKUP, 8'd0,   8'h00, 8'h00, 8'h00, 8'h00);
      send_item(KIND_LOOKUP, 8'd255, 8'hff, 8'hff, 8'hff, 8'hff);
   endtask

   // fixed-shift layouts
   task automatic test_fixed_formats();
      set_config(MODE_16, M555_RED, M555_GREEN, M5_BLUE);
      send_item(KIND_WRITE,  8'd1, 8'hff, 8'h80, 8'h07, 8'h55);
      send_item(KIND_LOOKUP, 8'd1, 8'h00, 8'h00, 8'h00, 8'h00);
      set_config(MODE_16, M565_RED, M565_GREEN, M5_BLUE);
      send_item(KIND_WRITE,  8'd2, 8'hf8, 8'hfc, 8'hf8, 8'haa);
      send_item(KIND_LOOKUP, 8'd2, 8'h00, 8'h00, 8'h00, 8'h00);
      // 24-bit RGB drops alpha
      set_config(MODE_24, RGB_RED, RGB_GREEN, RGB_BLUE);
      send_item(KIND_WRITE,  8'd3, 8'h12, 8'h34, 8'h56, 8'hab);
      send_item(KIND_LOOKUP, 8'd3, 8'h00, 8'h00, 8'h00, 8'h00);
      set_config(MODE_24, RGB_BLUE, RGB_GREEN, RGB_RED);
      send_item(KIND_WRITE,  8'd4, 8'h12, 8'h34, 8'h56, 8'hab);
      send_item(KIND_LOOKUP, 8'd4, 8'h00, 8'h00, 8'h00, 8'h00);
      // 32-bit BGR: alpha not kept either
      set_config(MODE_32, RGB_BLUE, RGB_GREEN, RGB_RED);
      send_item(KIND_WRITE,  8'd9, 8'h81, 8'h42, 8'h24, 8'hff);
      send_item(KIND_LOOKUP, 8'd9, 8'h00, 8'h00, 8'h00, 8'h00);
   endtask

   task automatic test_mask_corner_cases();
      // 24-bit with foreign masks: stored generically, looked up as an error
      set_config(MODE_24, M555_RED, M555_GREEN, M5_BLUE);
      send_item(KIND_WRITE,  8'd5, 8'hc3, 8'h3c, 8'h99, 8'h11);
      send_item(KIND_LOOKUP, 8'd5, 8'h00, 8'h00, 8'h00, 8'h00);
      // zero mask contributes nothing; all-ones and split masks
      set_config(MODE_32, 32'h0, 32'hffff_ffff, 32'h8000_0001);
      send_item(KIND_WRITE,  8'd6, 8'hff, 8'hff, 8'hff, 8'hff);
      send_item(KIND_LOOKUP, 8'd6, 8'h00, 8'h00, 8'h00, 8'h00);
      // single-bit masks at both ends, and a mid-word nibble pair
      set_config(MODE_32, 32'h1, 32'h8000_0000, 32'h0000_0ff0);
      send_item(KIND_WRITE,  8'd7, 8'h80, 8'h01, 8'hff, 8'h00);
      send_item(KIND_LOOKUP, 8'd7, 8'h00, 8'h00, 8'h00, 8'h00);
      // 16-bit generic: a channel shifted above bit 15 is cut off
      set_config(MODE_16, RGB_RED, 32'h0, 32'h0000_000f);
      send_item(KIND_WRITE,  8'd8, 8'hff, 8'hff, 8'hf0, 8'hff);
      send_item(KIND_LOOKUP, 8'd8, 8'h00, 8'h00, 8'h00, 8'h00);
   endtask

   task automatic test_index_passthrough();
      set_config(MODE_INDEX, RGB_RED, RGB_GREEN, RGB_BLUE);
      send_item(KIND_LOOKUP, 8'd200, 8'h00, 8'h00, 8'h00, 8'h00);
      send_item(KIND_WRITE,  8'd0,   8'h01, 8'h02, 8'h03, 8'h04);   // dropped
      send_item(KIND_LOOKUP, 8'd255, 8'h00, 8'h00, 8'h00, 8'h00);
      // words keep the packing they were written with
      set_config(MODE_32, RGB_RED, RGB_GREEN, RGB_BLUE);
      send_item(KIND_LOOKUP, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00);
      send_item(KIND_LOOKUP, 8'd5, 8'h00, 8'h00, 8'h00, 8'h00);
      send_item(KIND_LOOKUP, 8'd1, 8'h00, 8'h00, 8'h00, 8'h00);
   endtask

   task automatic test_random_traffic();
      int unsigned idle_tab  [4] = '{0, 47, 0, 24};
      int unsigned stall_tab [4] = '{0, 0, 47, 24};
      for (int p = 0; p < 4; p++) begin
         send_idle_pct = idle_tab[p];
         rsp_stall_pct = stall_tab[p];
         repeat (6) begin
            random_config();
            random_batch(80);
         end
      end
      send_idle_pct = 0;
      rsp_stall_pct = 0;
   endtask

   // long response hold while requests keep coming, so intake backs up;
   // then a full pause until every response is home, and a further batch
   task automatic test_backpressure();
      set_config(MODE_32, RGB_RED, RGB_GREEN, RGB_BLUE);
      fork
         hold_responses(150);
      join_none
      random_batch(40);
      wait_for_results();
      random_batch(20);
   endtask

   // ------------------------------------------------------------ sequence
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_fixed_formats();
      test_mask_corner_cases();
      test_index_passthrough();
      test_random_traffic();
      test_backpressure();
      wait_for_results();
      $display("Covered %0d palette writes and %0d lookups (%0d responses checked)",
               n_writes, n_lookups, n_results);
      $display("over %0d register settings in all pixel modes, with idle, stall and hold phases",
               n_configs);
      if (fail_count == 0 && pending_pixels.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
